// ----- hdl/pcs_pkg.sv -----
// Shared constants, types and sequencer states for the pancake sorter.
package pcs_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_OUTER,
        ST_SCAN,
        ST_DECIDE,
        ST_FLIP_RD,
        ST_FLIP_W1,
        ST_FLIP_W2,
        ST_EMIT_RD,
        ST_EMIT
    } pcs_state_t;

    // One result handed from the engine to the output register
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflow;
    } pcs_emit_t;

endpackage

// ----- hdl/pcs_ram.sv -----
// Generic simple dual-port RAM: one write port, two registered read ports.
module pcs_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6,
    parameter int DEPTH  = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- hdl/pcs_engine.sv -----
// Load, pancake-sort and read-out sequencer working on the element memory.
module pcs_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pcs_pkg::DATA_W-1:0] s_value,
    input  logic                              s_last,
    output logic                              emit_valid,
    input  logic                              emit_ready,
    output pcs_pkg::pcs_emit_t                emit
);
    import pcs_pkg::*;

    pcs_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] pend_reg, pend_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic              flip2_reg, flip2_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next;
    logic [CNT_W-1:0]  eidx_reg, eidx_next;

    // Memory port signals
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic [DATA_W-1:0] rd_data_a, rd_data_b;

    // Helpers
    logic              in_txn;
    logic              has_room;
    logic [CNT_W-1:0]  count_inc;
    logic              scan_take;
    logic              scan_end;
    logic [CNT_W-1:0]  size_dec;
    logic              emit_last;

    pcs_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign in_txn    = s_valid && s_ready;
    assign has_room  = (count_reg < CNT_W'(DEPTH));
    assign count_inc = count_reg + CNT_W'(1);
    assign scan_take = (pend_reg == '0) || ($signed(rd_data_a) > best_val_reg);
    assign scan_end  = ({1'b0, pend_reg} + CNT_W'(1)) == size_reg;
    assign size_dec  = size_reg - CNT_W'(1);
    assign emit_last = (eidx_reg + CNT_W'(1)) == count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (in_txn && s_last) begin
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER: begin
                if (size_reg <= CNT_W'(1)) begin
                    state_next = ST_EMIT_RD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ({1'b0, best_reg} == size_dec) begin
                    state_next = ST_OUTER;
                end else begin
                    state_next = ST_FLIP_RD;
                end
            end
            ST_FLIP_RD: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_FLIP_W1;
                end else if (!flip2_reg) begin
                    state_next = ST_OUTER;
                end
            end
            ST_FLIP_W1: state_next = ST_FLIP_W2;
            ST_FLIP_W2: state_next = ST_FLIP_RD;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (emit_ready) begin
                    state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Outputs, memory accesses and datapath updates
    always_comb begin
        s_ready        = 1'b0;
        emit_valid     = 1'b0;
        emit.value     = $signed(rd_data_a);
        emit.last      = emit_last;
        emit.overflow  = ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = lo_reg;
        wr_data        = rd_data_b;
        rd_addr_a      = lo_reg;
        rd_addr_b      = hi_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        size_next      = size_reg;
        pend_next      = pend_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        flip2_next     = flip2_reg;
        tmp_next       = tmp_reg;
        eidx_next      = eidx_reg;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                wr_addr = count_reg[ADDR_W-1:0];
                wr_data = s_value;
                if (in_txn) begin
                    if (has_room) begin
                        wr_en      = 1'b1;
                        count_next = count_inc;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_last) begin
                        size_next = has_room ? count_inc : count_reg;
                    end
                end
            end
            ST_OUTER: begin
                // Start the max scan of the current prefix at entry 0
                rd_addr_a = '0;
                pend_next = '0;
                eidx_next = '0;
            end
            ST_SCAN: begin
                rd_addr_a = pend_reg + ADDR_W'(1);
                pend_next = pend_reg + ADDR_W'(1);
                if (scan_take) begin
                    best_next     = pend_reg;
                    best_val_next = $signed(rd_data_a);
                end
            end
            ST_DECIDE: begin
                lo_next = '0;
                if ({1'b0, best_reg} == size_dec) begin
                    size_next = size_dec;
                end else if (best_reg != '0) begin
                    hi_next    = best_reg;
                    flip2_next = 1'b1;
                end else begin
                    hi_next    = size_dec[ADDR_W-1:0];
                    flip2_next = 1'b0;
                end
            end
            ST_FLIP_RD: begin
                if (!(lo_reg < hi_reg)) begin
                    if (flip2_reg) begin
                        // Whole-prefix flip follows the flip to front
                        lo_next    = '0;
                        hi_next    = size_dec[ADDR_W-1:0];
                        flip2_next = 1'b0;
                    end else begin
                        size_next = size_dec;
                    end
                end
            end
            ST_FLIP_W1: begin
                wr_en    = 1'b1;
                wr_addr  = lo_reg;
                wr_data  = rd_data_b;
                tmp_next = rd_data_a;
            end
            ST_FLIP_W2: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + ADDR_W'(1);
                hi_next = hi_reg - ADDR_W'(1);
            end
            ST_EMIT_RD: begin
                rd_addr_a = eidx_reg[ADDR_W-1:0];
            end
            ST_EMIT: begin
                rd_addr_a  = eidx_reg[ADDR_W-1:0];
                emit_valid = 1'b1;
                if (emit_ready) begin
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        eidx_next = eidx_reg + CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        size_reg     <= size_next;
        pend_reg     <= pend_next;
        best_reg     <= best_next;
        best_val_reg <= best_val_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        flip2_reg    <= flip2_next;
        tmp_reg      <= tmp_next;
        eidx_reg     <= eidx_next;
    end

endmodule

// ----- hdl/pancake_sorter.sv -----
// Pancake sorter top level: sort engine plus registered result channel.
//
// Elements are taken one per cycle until the transaction marked s_last; at
// most 64 are kept, later ones are dropped and m_overflow is set on every
// result of that set. Once the set closes, input is held off while the set is
// pancake-sorted in a single-write-port element memory: each pass over a
// prefix scans it for its largest entry and then decides, and each flip
// swaps entries pair by pair, reading a pair through both read ports at once
// and then writing it back through the one write port in two steps. Results
// then leave in ascending order, each read from memory and then handed off,
// with m_last_out on the final one; the next set is accepted as soon as the
// last result has moved into the output register.
module pancake_sorter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pcs_pkg::DATA_W-1:0] s_value,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pcs_pkg::DATA_W-1:0] m_sorted_value,
    output logic                              m_last_out,
    output logic                              m_overflow
);
    import pcs_pkg::*;

    logic      emit_valid;
    logic      emit_ready;
    pcs_emit_t emit;

    logic      m_valid_reg, m_valid_next;
    pcs_emit_t out_reg, out_next;

    pcs_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_last     (s_last),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit       (emit)
    );

    // Output register: refills when empty or being drained
    assign emit_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (emit_ready) begin
            m_valid_next = emit_valid;
            if (emit_valid) begin
                out_next = emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = out_reg.value;
    assign m_last_out     = out_reg.last;
    assign m_overflow     = out_reg.overflow;

endmodule

// ----- hdl/pcs_checker.sv -----
// Port-level checks for the pancake sorter, bound to the top level.
module pcs_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [pcs_pkg::DATA_W-1:0] s_value,
    input logic                              s_last,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [pcs_pkg::DATA_W-1:0] m_sorted_value,
    input logic                              m_last_out,
    input logic                              m_overflow
);

    // Closing a set stops input while the sort runs
    a_close_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=> !s_ready)
        else $error("input still ready after set closed");

    // A fresh result never appears while elements are still being loaded
    a_no_result_during_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while loading");

    // A stalled result holds
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sorted_value)
                                   && $stable(m_last_out) && $stable(m_overflow)))
        else $error("stalled result changed");

endmodule

bind pancake_sorter pcs_checker u_pcs_checker (.*);

// ----- verif/tb_pancake_sorter.sv -----
// Self-checking testbench for the pancake sorter: sets in, sorted results out.
`timescale 1ns / 1ps

module tb_pancake_sorter;
    import pcs_pkg::*;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // One sorted element as it should leave the block
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_out;
        logic                     overflow;
    } sorted_result_t;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     s_last  = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_last_out;
    logic                     m_overflow;

    // Predictor state: the set being collected
    logic signed [DATA_W-1:0] set_buf [DEPTH];
    int                       set_count    = 0;
    logic                     set_overflow = 1'b0;
    sorted_result_t           expected_sorted_q [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;

    always #10 aclk = ~aclk;

    pancake_sorter uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_overflow     (m_overflow)
    );

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Reverse entries 0 .. n-1 of the collected set
    function automatic void flip_front(input int n);
        logic signed [DATA_W-1:0] tmp;
        int lo;
        int hi;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            tmp         = set_buf[lo];
            set_buf[lo] = set_buf[hi];
            set_buf[hi] = tmp;
            lo++;
            hi--;
        end
    endfunction

    // Move the first largest of each shrinking prefix to its end
    function automatic void pancake_sort_set(input int n);
        int size;
        int best;
        int a;
        for (size = n; size > 1; size--) begin
            best = 0;
            for (a = 1; a < size; a++)
                if (set_buf[a] > set_buf[best])
                    best = a;
            if (best != size - 1) begin
                if (best != 0)
                    flip_front(best + 1);
                flip_front(size);
            end
        end
    endfunction

    // Take one accepted element; a closing element queues the sorted set
    function automatic void absorb_element(input logic signed [DATA_W-1:0] value,
                                           input logic last);
        sorted_result_t r;
        int k;
        if (set_count < DEPTH) begin
            set_buf[set_count] = value;
            set_count++;
        end else begin
            set_overflow = 1'b1;
        end
        if (last) begin
            pancake_sort_set(set_count);
            for (k = 0; k < set_count; k++) begin
                r.value    = set_buf[k];
                r.last_out = (k == set_count - 1);
                r.overflow = set_overflow;
                expected_sorted_q.push_back(r);
            end
            set_count    = 0;
            set_overflow = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: ready generation and checking
    // ---------------------------------------------------------------

    // Ready: a requested hold-off first, then random stalls
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        sorted_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_sorted_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d",
                         $time, m_sorted_value);
                mismatch_count++;
            end else begin
                want = expected_sorted_q.pop_front();
                if (m_sorted_value !== want.value) begin
                    $display("%0t: sorted_value mismatch, expected %0d, got %0d",
                             $time, want.value, m_sorted_value);
                    mismatch_count++;
                end
                if (m_last_out !== want.last_out) begin
                    $display("%0t: last_out mismatch, expected %0b, got %0b",
                             $time, want.last_out, m_last_out);
                    mismatch_count++;
                end
                if (m_overflow !== want.overflow) begin
                    $display("%0t: overflow mismatch, expected %0b, got %0b",
                             $time, want.overflow, m_overflow);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Offer one element and wait for its transaction; valid stays up afterwards
    task automatic send_element(input logic signed [DATA_W-1:0] value, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_last  <= last;
        do @(posedge aclk); while (!s_ready);
        absorb_element(value, last);
        items_sent++;
    endtask

    // Drop valid and pause until every expected result has come
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_sorted_q.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_list(input logic signed [DATA_W-1:0] vals [$]);
        int i;
        for (i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
    endtask

    // Mix of full-range, clustered (many ties) and extreme values
    function automatic logic signed [DATA_W-1:0] rand_element();
        case ($urandom_range(9))
            5, 6:    return $signed($urandom_range(8)) - 4;
            7: begin
                case ($urandom_range(3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_element(rand_element(), i == n - 1);
    endtask

    // Mostly short sets; now and then a nearly full, full or overfull one
    function automatic int pick_set_size();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return $urandom_range(DEPTH - 4, DEPTH);
        else if (r < 7)
            return $urandom_range(DEPTH + 1, DEPTH + 6);
        else
            return $urandom_range(1, 12);
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_single_element();
        send_list('{VAL_MIN});
        send_list('{VAL_MAX});
    endtask

    task automatic test_extreme_values();
        send_list('{VAL_MAX, VAL_MIN, 0, -1, 1});
    endtask

    // Ties, including a tie for the largest value
    task automatic test_equal_values();
        send_list('{5, 5, -3, 5});
    endtask

    // Largest already in place, largest at the front, and largest in the middle
    task automatic test_sorted_and_reversed();
        send_list('{-2, 1, 3});
        send_list('{3, 1, -2});
        send_list('{7, 9, 8, 6});
    endtask

    // Exactly full set, then a set whose closing element is dropped
    task automatic test_capacity_limits();
        send_random_set(DEPTH);
        send_random_set(DEPTH + 1);
        wait_for_results();
    endtask

    task automatic test_random_sets(input int target);
        int start;
        start = items_sent;
        while (items_sent - start < target)
            send_random_set(pick_set_size());
        wait_for_results();
    endtask

    // Long output stall while sets keep coming: input must back up
    task automatic test_output_stall();
        tx_idle_pct    = 0;
        rx_hold_cycles = 500;
        send_random_set(10);
        send_random_set(12);
        send_random_set(8);
        wait_for_results();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 17;
        rx_idle_pct = 65;
        test_single_element();
        test_extreme_values();
        test_equal_values();
        test_sorted_and_reversed();
        test_capacity_limits();
        test_random_sets(75);

        tx_idle_pct = 65;
        rx_idle_pct = 17;
        test_random_sets(75);
        test_output_stall();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sets(75);

        wait_for_results();
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS pancake_sorter");
        else
            $display("FAIL pancake_sorter");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("FAIL pancake_sorter");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/pcs_pkg.sv
hdl/pcs_ram.sv
hdl/pcs_engine.sv
hdl/pancake_sorter.sv
hdl/pcs_checker.sv
verif/tb_pancake_sorter.sv
